// ===== rtl/pattern_class_string_search_top_macros.svh =====
// assertion macros for the pattern class string search block
// used by rtl files that carry concurrent assertions; no other dependencies
`ifndef PATTERN_CLASS_STRING_SEARCH_TOP_MACROS_SVH
`define PATTERN_CLASS_STRING_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked on every rising clock edge outside reset
`define PCSS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcss assertion failed");
// checked on every rising clock edge, reset included
`define PCSS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pcss assertion failed");
`else
`define PCSS_ASSERT(lbl, clk, rst, prop)
`define PCSS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/pcss_pkg.sv =====
// shared types and constants for the pattern class string search block
// no dependencies
package pcss_pkg;

   localparam int SLOT_COUNT    = 16;
   localparam int ELEMS_PER_REG = 4;
   localparam int ELEM_W        = 16;
   localparam int LEN_W         = 5;
   localparam int BYTE_W        = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int SLOT_REGS     = SLOT_COUNT / ELEMS_PER_REG;

   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_UP_A    = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UP_Z    = 8'h5a;
   localparam logic [BYTE_W-1:0] CHAR_LO_A    = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LO_Z    = 8'h7a;
   localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0d;
   localparam logic [BYTE_W-1:0] CASE_BIT     = 8'h20;

   typedef enum logic [2:0] {
      CLS_DIGIT  = 3'd0,
      CLS_LETTER = 3'd1,
      CLS_ANY    = 3'd2,
      CLS_NOCASE = 3'd3,
      CLS_EXACT  = 3'd4
   } elem_class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LENGTH  = 3'd0,
      CSR_SLOTS_A = 3'd1,
      CSR_SLOTS_B = 3'd2,
      CSR_SLOTS_C = 3'd3,
      CSR_SLOTS_D = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [4:0]         spare;
      elem_class_type     cls;
      logic [BYTE_W-1:0]  value;
   } elem_type;

   typedef struct packed {
      logic [LEN_W-1:0]             eff_len;
      elem_type [SLOT_COUNT-1:0]    elems;
   } pattern_cfg_type;

endpackage

// ===== rtl/pcss_csr.sv =====
// configuration registers: pattern length and the four element slot words
// depends on pcss_pkg
module pcss_csr #(
   parameter int ELEMS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [pcss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pcss_pkg::CSR_DATA_W-1:0]       csr_data,
   output pcss_pkg::pattern_cfg_type             cfg
);
   import pcss_pkg::*;

   logic [LEN_W-1:0]      length_ff, length_in;
   logic [CSR_DATA_W-1:0] slots_ff [SLOT_REGS];
   logic [CSR_DATA_W-1:0] slots_in [SLOT_REGS];

   always_comb begin
      length_in = length_ff;
      for (int r = 0; r < SLOT_REGS; r++) begin
         slots_in[r] = slots_ff[r];
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LENGTH:  length_in  = csr_data[LEN_W-1:0];
            CSR_SLOTS_A: slots_in[0] = csr_data;
            CSR_SLOTS_B: slots_in[1] = csr_data;
            CSR_SLOTS_C: slots_in[2] = csr_data;
            CSR_SLOTS_D: slots_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         for (int r = 0; r < SLOT_REGS; r++) begin
            slots_ff[r] <= '0;
         end
      end else begin
         length_ff <= length_in;
         for (int r = 0; r < SLOT_REGS; r++) begin
            slots_ff[r] <= slots_in[r];
         end
      end
   end

   // length saturates at the number of implemented elements
   always_comb begin
      if (length_ff > LEN_W'(ELEMS)) begin
         cfg.eff_len = LEN_W'(ELEMS);
      end else begin
         cfg.eff_len = length_ff;
      end
      for (int k = 0; k < SLOT_COUNT; k++) begin
         cfg.elems[k] = slots_ff[k / ELEMS_PER_REG][(k % ELEMS_PER_REG) * ELEM_W +: ELEM_W];
      end
   end

endmodule

// ===== rtl/pcss_match.sv =====
// per-element class match of one text byte against the compiled pattern
// depends on pcss_pkg
module pcss_match #(
   parameter int ELEMS = 16
) (
   input  logic [pcss_pkg::BYTE_W-1:0]  text_byte,
   input  pcss_pkg::pattern_cfg_type    cfg,
   output logic [ELEMS-1:0]             match_mask
);
   import pcss_pkg::*;

   logic              is_digit;
   logic              is_upper;
   logic              is_lower;
   logic              is_line_end;
   logic [BYTE_W-1:0] text_fold;

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         r = c | CASE_BIT;
      end
      return r;
   endfunction

   assign is_digit    = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign is_upper    = (text_byte >= CHAR_UP_A) && (text_byte <= CHAR_UP_Z);
   assign is_lower    = (text_byte >= CHAR_LO_A) && (text_byte <= CHAR_LO_Z);
   assign is_line_end = (text_byte == CHAR_LF) || (text_byte == CHAR_CR);
   assign text_fold   = fold_case(text_byte);

   always_comb begin
      for (int k = 0; k < ELEMS; k++) begin
         logic hit;
         hit = 1'b0;
         case (cfg.elems[k].cls)
            CLS_DIGIT:  hit = is_digit;
            CLS_LETTER: hit = is_upper || is_lower;
            CLS_ANY:    hit = !is_line_end;
            CLS_NOCASE: hit = (text_fold == fold_case(cfg.elems[k].value));
            CLS_EXACT:  hit = (text_byte == cfg.elems[k].value);
            default:    hit = 1'b0;
         endcase
         match_mask[k] = hit && (LEN_W'(k) < cfg.eff_len);
      end
   end

endmodule

// ===== rtl/pattern_class_string_search_top.sv =====
// pattern class string search: request register, shift-and prefix update, result register
// depends on pcss_pkg, pcss_csr, pcss_match and pattern_class_string_search_top_macros.svh
// throughput: one request per cycle; the prefix update uses combinational class compares
// a final request waits in the request register only while an earlier result is not taken
// reset: synchronous, active high; clears prefixes and handshake state, not the payload registers
`include "pattern_class_string_search_top_macros.svh"

module pattern_class_string_search_top #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_text_byte,
   input  logic                                  req_has_byte,
   input  logic                                  req_final_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pcss_pkg::CSR_DATA_W-1:0]       csr_data
);
   import pcss_pkg::*;

   localparam int ELEMS = (MAX_PATTERN < SLOT_COUNT) ? MAX_PATTERN : SLOT_COUNT;

   pattern_cfg_type   cfg;
   logic [ELEMS-1:0]  match_mask;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_has_byte_ff;
   logic              s1_final_ff;
   logic              s1_fire;
   logic              req_fire;

   logic [ELEMS-1:0]  active_ff, active_in;
   logic              seen_ff, seen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;

   logic [ELEMS-1:0]  shifted;
   logic [ELEMS-1:0]  last_sel;
   logic              hit;

   assign csr_ready = 1'b1;

   pcss_csr #(.ELEMS(ELEMS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pcss_match #(.ELEMS(ELEMS)) u_match (
      .text_byte  (s1_byte_ff),
      .cfg        (cfg),
      .match_mask (match_mask)
   );

   // a final request needs the result slot free
   assign s1_fire   = s1_valid_ff && (!s1_final_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   always_comb begin
      if (ELEMS > 1) begin
         shifted = (active_ff << 1) | ELEMS'(1);
      end else begin
         shifted = ELEMS'(1);
      end
      for (int k = 0; k < ELEMS; k++) begin
         last_sel[k] = (cfg.eff_len == LEN_W'(k + 1));
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      active_in    = active_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      hit          = 1'b0;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         if (s1_has_byte_ff && (cfg.eff_len != '0)) begin
            active_in = shifted & match_mask;
            hit       = |(active_in & last_sel);
            seen_in   = seen_ff || hit;
         end
         if (s1_final_ff) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = seen_in || (cfg.eff_len == '0);
            active_in    = '0;
            seen_in      = 1'b0;
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         active_ff    <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         active_ff    <= active_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff     <= req_text_byte;
         s1_has_byte_ff <= req_has_byte;
         s1_final_ff    <= req_final_req;
      end
      rsp_found_ff <= rsp_found_in;
   end

   // end of string leaves the search state cleared
   `PCSS_ASSERT(a_final_clears, clock, reset,
      (s1_fire && s1_final_ff) |=> (active_ff == '0) && !seen_ff)
   // a pending result is never overwritten by the next final request
   `PCSS_ASSERT(a_no_overwrite, clock, reset,
      (rsp_valid_ff && !rsp_ready && s1_valid_ff && s1_final_ff) |-> !s1_fire)
   // empty pattern always reports a match
   `PCSS_ASSERT(a_empty_found, clock, reset,
      (s1_fire && s1_final_ff && (cfg.eff_len == '0)) |=> rsp_valid && rsp_found)
   // only a final request raises the result valid
   `PCSS_ASSERT(a_rsp_source, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s1_fire && s1_final_ff))

endmodule

// ===== verif/tb_pattern_class_string_search_top.sv =====
// self-checking testbench for pattern_class_string_search_top: directed table, then random strings
// built around the configured pattern, checked against a shift-and predictor or a typed expectation
// depends on pcss_pkg and the rtl of pattern_class_string_search_top
`timescale 1ns / 100ps

module tb_pattern_class_string_search_top;
   import pcss_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int PAT_MAX         = 16;
   localparam int ITEM_TARGET     = 1750;
   localparam int PHASE_ITEMS     = 140;
   localparam int HOLD_PHASE      = 5;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int PIPE_CYCLES     = 4;
   localparam int DRAIN_CYCLES    = 8;
   localparam int IDLE_LIMIT      = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [7:0]            text;
      bit                    has;
      bit                    fin;
      bit                    typed;
      bit                    want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_text_byte;
   logic                  req_has_byte;
   logic                  req_final_req;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_found;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor state and configuration copy
   logic [15:0]           live_prefixes;
   bit                    match_seen;
   logic [LEN_W-1:0]      cfg_len;
   logic [CSR_DATA_W-1:0] cfg_slots [SLOT_REGS];

   bit                    expected_found [$];
   stim_row_type          directed_rows [$];

   bit req_up;
   bit csr_up;
   bit bursty;
   bit hold_rsp;
   int burst_left;
   int idle_cycles;
   int mismatches;
   int requests_sent;
   int strings_sent;
   int results_checked;
   int settings_used;

   pattern_class_string_search_top #(
      .MAX_PATTERN (PAT_MAX)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .req_has_byte  (req_has_byte),
      .req_final_req (req_final_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [15:0] mk_elem(input logic [4:0] spare, input logic [2:0] cls,
                                           input logic [7:0] value);
      return {spare, cls, value};
   endfunction

   function automatic logic [15:0] slot_elem(input int k);
      return cfg_slots[k / ELEMS_PER_REG][(k % ELEMS_PER_REG) * ELEM_W +: ELEM_W];
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z);
   endfunction

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? (c | CASE_BIT) : c;
   endfunction

   function automatic bit elem_accepts(input logic [15:0] raw, input logic [7:0] t);
      elem_type e;
      e = elem_type'(raw);
      case (e.cls)
         CLS_DIGIT:  return t >= CHAR_ZERO && t <= CHAR_NINE;
         CLS_LETTER: return is_letter(t);
         CLS_ANY:    return t != CHAR_LF && t != CHAR_CR;
         CLS_NOCASE: return fold_lower(t) == fold_lower(e.value);
         CLS_EXACT:  return t == e.value;
         default:    return 1'b0;
      endcase
   endfunction

   function automatic int active_len();
      int n;
      n = int'(cfg_len);
      if (n > PAT_MAX) n = PAT_MAX;
      if (n > SLOT_COUNT) n = SLOT_COUNT;
      return n;
   endfunction

   // returns 1 when the request ends a string; found_now holds the predicted result
   function automatic bit advance_search(input logic [7:0] t, input bit has, input bit fin,
                                         output bit found_now);
      int n;
      int k;
      logic [15:0] hits;
      n = active_len();
      if (has && n > 0) begin
         hits = '0;
         for (k = 0; k < n; k++) hits[k] = elem_accepts(slot_elem(k), t);
         live_prefixes = ((live_prefixes << 1) | 16'd1) & hits;
         if (live_prefixes[n-1]) match_seen = 1'b1;
      end
      found_now = match_seen || n == 0;
      if (fin) begin
         live_prefixes = '0;
         match_seen = 1'b0;
      end
      return fin;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LENGTH:  cfg_len = data[LEN_W-1:0];
         CSR_SLOTS_A: cfg_slots[0] = data;
         CSR_SLOTS_B: cfg_slots[1] = data;
         CSR_SLOTS_C: cfg_slots[2] = data;
         CSR_SLOTS_D: cfg_slots[3] = data;
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] byte_for(input logic [15:0] raw);
      elem_type e;
      logic [7:0] b;
      e = elem_type'(raw);
      case (e.cls)
         CLS_DIGIT:  b = CHAR_ZERO + 8'($urandom_range(0, 9));
         CLS_LETTER: b = ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'($urandom_range(0, 25));
         CLS_ANY: begin
            do b = 8'($urandom); while (b == CHAR_LF || b == CHAR_CR);
         end
         CLS_NOCASE: b = (is_letter(e.value) && $urandom_range(0, 1)) ? (e.value ^ CASE_BIT) : e.value;
         CLS_EXACT:  b = e.value;
         default:    b = 8'($urandom);
      endcase
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0:       return CHAR_ZERO + 8'($urandom_range(0, 9));
         1:       return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LO_A) + 8'($urandom_range(0, 25));
         2:       return $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
         3:       return byte_for(slot_elem($urandom_range(0, SLOT_COUNT - 1)));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_elem();
      logic [2:0] cls;
      logic [7:0] value;
      cls = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
         0:       value = CHAR_LO_A + 8'($urandom_range(0, 25));
         1:       value = CHAR_UP_A + 8'($urandom_range(0, 25));
         2:       value = 8'($urandom_range(32, 126));
         default: value = 8'($urandom);
      endcase
      return mk_elem(5'($urandom), cls, value);
   endfunction

   function automatic void add_item(input logic [7:0] text, input bit has, input bit fin,
                                    input bit typed, input bit want);
      stim_row_type r;
      r = '{ROW_ITEM, '0, '0, text, has, fin, typed, want};
      directed_rows.push_back(r);
   endfunction

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r = '{ROW_WRITE, idx, data, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
      directed_rows.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic got, input logic want);
      $display("mismatch at %0t: %s: got %b, expected %b", $time, what, got, want);
      mismatches++;
   endtask

   task automatic drop_req();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   task automatic drop_csr();
      if (csr_up) begin
         csr_valid <= 1'b0;
         csr_up = 1'b0;
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_up = 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      apply_csr(idx, data);
   endtask

   task automatic send_item(input logic [7:0] text, input bit has, input bit fin,
                            input bit typed, input bit want);
      bit ends;
      bit found_now;
      req_valid <= 1'b1;
      req_up = 1'b1;
      req_text_byte <= text;
      req_has_byte <= has;
      req_final_req <= fin;
      do @(posedge clock); while (req_ready !== 1'b1);
      ends = advance_search(text, has, fin, found_now);
      if (ends) expected_found.push_back(typed ? want : found_now);
      if (has || fin) requests_sent++;
      if (bursty) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            drop_req();
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // idle point for register writes: every result in, pipeline flushed
   task automatic settle();
      drop_req();
      while (expected_found.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic send_string(input logic [7:0] text [$]);
      int i;
      bit sep_end;
      sep_end = text.size() == 0 || $urandom_range(0, 3) == 0;
      for (i = 0; i < text.size(); i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0, 1'b0, 1'b0);
         send_item(text[i], 1'b1, !sep_end && i == text.size() - 1, 1'b0, 1'b0);
      end
      if (sep_end) send_item(8'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
      strings_sent++;
   endtask

   // noise around a full, broken or missing copy of the pattern
   task automatic send_random_string(input bit short_only);
      logic [7:0] text [$];
      int n;
      int k;
      int cut;
      n = active_len();
      repeat ($urandom_range(0, short_only ? 2 : 6)) text.push_back(noise_byte());
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            for (k = 0; k < n; k++) text.push_back(byte_for(slot_elem(k)));
         end
         6, 7: begin
            cut = (n > 0) ? $urandom_range(0, n - 1) : 0;
            for (k = 0; k < n; k++) text.push_back(k == cut ? noise_byte() : byte_for(slot_elem(k)));
         end
         default: ;
      endcase
      repeat ($urandom_range(0, short_only ? 2 : 6)) text.push_back(noise_byte());
      send_string(text);
   endtask

   task automatic configure_phase(input int phase);
      logic [CSR_DATA_W-1:0] regs [SLOT_REGS];
      logic [LEN_W-1:0] len;
      int r;
      int k;
      for (r = 0; r < SLOT_REGS; r++)
         for (k = 0; k < ELEMS_PER_REG; k++) regs[r][k*ELEM_W +: ELEM_W] = rand_elem();
      len = 5'($urandom_range(1, 6));
      if ($urandom_range(0, 3) == 0) len = 5'($urandom_range(7, 16));
      if ($urandom_range(0, 7) == 0) len = 5'($urandom_range(17, 31));
      case (phase)
         0: len = '0;
         1: len = 5'd16;
         2: len = 5'd31;
         3: begin
            for (r = 0; r < SLOT_REGS; r++) regs[r] = '0;
            len = 5'd3;
         end
         4: begin
            for (r = 0; r < SLOT_REGS; r++) regs[r] = '1;
            len = 5'd16;
         end
         HOLD_PHASE: len = 5'($urandom_range(1, 3));
         default: ;
      endcase
      for (r = 0; r < SLOT_REGS; r++) csr_write(CSR_SLOTS_A + 3'(r), regs[r]);
      csr_write(CSR_LENGTH, {59'({$urandom, $urandom}), len});
      drop_csr();
      settings_used++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_checked++;
         if (expected_found.size() == 0) report_mismatch("result with no string ended", rsp_found, 1'bx);
         else begin
            if (rsp_found !== expected_found[0]) report_mismatch("found", rsp_found, expected_found[0]);
            void'(expected_found.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request, result or write for %0d cycles", IDLE_LIMIT);
            $display("pattern_class_string_search_top regression: fail");
            $finish;
         end
      end
   end

   // receiver pacing, with a long hold-off on request
   initial begin : rsp_pacing
      int run_left;
      int pace;
      int held;
      int tick;
      rsp_ready = 1'b0;
      run_left = 0;
      pace = 0;
      held = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            held++;
            if (held >= RSP_HOLD_CYCLES) begin
               hold_rsp = 1'b0;
               held = 0;
            end
         end else begin
            if (run_left == 0) begin
               pace = $urandom_range(0, 3);
               run_left = $urandom_range(4, 64);
            end
            run_left--;
            case (pace)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= $urandom_range(0, 4) == 0;
               default: rsp_ready <= (tick % 3) != 0;
            endcase
         end
      end
   end

   initial begin : main
      stim_row_type row;
      int phase;
      int phase_start;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_text_byte = '0;
      req_has_byte = 1'b0;
      req_final_req = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      live_prefixes = '0;
      match_seen = 1'b0;
      cfg_len = '0;
      for (int r = 0; r < SLOT_REGS; r++) cfg_slots[r] = '0;
      bursty = 1'b1;

      // empty pattern after reset matches everything
      add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      add_item(8'hff, 1'b0, 1'b0, 1'b0, 1'b0);
      add_item(8'hff, 1'b1, 1'b1, 1'b1, 1'b1);
      // digit, letter, any, caseless k; junk in spare bits and high length bits
      add_write(CSR_SLOTS_A, {mk_elem(5'h00, CLS_NOCASE, "k"), mk_elem(5'h1f, CLS_ANY, CHAR_LF),
                              mk_elem(5'h1f, CLS_LETTER, 8'h00), mk_elem(5'h00, CLS_DIGIT, 8'h00)});
      add_write(CSR_LENGTH, 64'hffff_ffff_ffff_ffe4);
      add_write(CSR_SPARE_IDX, '1);
      add_item("5", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("a", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("!", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("K", 1'b1, 1'b1, 1'b0, 1'b0);
      add_item("7", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("Z", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(CHAR_LF, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("k", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
      // exact bytes at both extremes, caseless uppercase letter, caseless non-letter
      add_write(CSR_SLOTS_A, {mk_elem(5'h00, CLS_NOCASE, "["), mk_elem(5'h00, CLS_NOCASE, "Q"),
                              mk_elem(5'h00, CLS_EXACT, 8'hff), mk_elem(5'h00, CLS_EXACT, 8'h00)});
      add_write(CSR_LENGTH, 64'd4);
      add_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("q", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("[", 1'b1, 1'b1, 1'b0, 1'b0);
      add_item(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item(8'hff, 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("Q", 1'b1, 1'b0, 1'b0, 1'b0);
      add_item("{", 1'b1, 1'b1, 1'b0, 1'b0);
      // oversized length with undefined classes in the upper slots
      add_write(CSR_SLOTS_B, '1);
      add_write(CSR_SLOTS_C, '1);
      add_write(CSR_SLOTS_D, '1);
      add_write(CSR_LENGTH, 64'd31);
      add_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            if (!csr_up) settle();
            csr_write(row.idx, row.data);
         end else begin
            drop_csr();
            send_item(row.text, row.has, row.fin, row.typed, row.want);
         end
      end

      for (phase = 0; requests_sent < ITEM_TARGET; phase++) begin
         settle();
         configure_phase(phase);
         bursty = (phase % 3) != 0;
         if (phase == HOLD_PHASE) hold_rsp = 1'b1;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) send_random_string(phase == HOLD_PHASE);
      end

      drop_req();
      while (expected_found.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests in %0d strings under %0d pattern settings", requests_sent,
               strings_sent, settings_used + 3);
      $display("empty, saturated, all-zero and undefined-class patterns included; %0d results, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("pattern_class_string_search_top regression: pass");
      end else begin
         $display("pattern_class_string_search_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pcss_pkg.sv
rtl/pcss_csr.sv
rtl/pcss_match.sv
rtl/pattern_class_string_search_top.sv
verif/tb_pattern_class_string_search_top.sv
